[rtl/edsm_pkg.sv]
// Shared types, constants, coefficient tables and helpers for the delta-sigma modulator.
`default_nettype none

package edsm_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = DATA_WIDTH - 5;
  localparam int SAMPLE_W   = 32;
  localparam int IN_FRAC    = 27;
  localparam int LEVEL_W    = 5;
  localparam int COEF_W     = 16;
  localparam int COEF_FRAC  = 11;
  localparam int PROD_W     = DATA_WIDTH + COEF_W;
  localparam int ACC_W      = DATA_WIDTH + 18;

  // input rescaling to the internal fraction width
  localparam int SH_UP  = (FRAC_BITS >= IN_FRAC) ? (FRAC_BITS - IN_FRAC) : 0;
  localparam int SH_DN  = (FRAC_BITS >= IN_FRAC) ? 0 : (IN_FRAC - FRAC_BITS);
  localparam int IN_RND = (SH_DN > 0) ? (1 << (SH_DN - 1)) : 0;

  localparam logic signed [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic signed [DATA_WIDTH:0]   Q_HALF   = (DATA_WIDTH+1)'(1) <<< (FRAC_BITS-1);
  localparam logic signed [ACC_W-1:0]      ACC_HALF = ACC_W'(1) <<< (COEF_FRAC-1);

  localparam logic signed [5:0] LEVEL_MAX = 6'sd15;
  localparam logic signed [5:0] LEVEL_MIN = -6'sd16;

  // multiply-accumulate programme: one term per step
  localparam int NUM_STEPS = 12;
  localparam int STEP_W    = $clog2(NUM_STEPS);

  typedef enum logic [2:0] {
    OP_E, OP_D0, OP_D11, OP_D12, OP_D21, OP_D22, OP_W1, OP_W2
  } operand_t;

  typedef enum logic [2:0] {
    GRP_X0, GRP_W1, GRP_X1, GRP_W2, GRP_X2
  } grp_t;

  localparam logic signed [COEF_W-1:0] STEP_COEF [NUM_STEPS] = '{
    16'(15104), 16'(710),
    16'(2048),  16'(1364), 16'(-333),
    16'(868),   16'(-5700),
    16'(2048),  16'(1278), 16'(-924),
    16'(-9432), 16'(48)
  };

  localparam operand_t STEP_OP [NUM_STEPS] = '{
    OP_E,  OP_D0,
    OP_E,  OP_D11, OP_D12,
    OP_W1, OP_D11,
    OP_E,  OP_D21, OP_D22,
    OP_W2, OP_D21
  };

  localparam grp_t STEP_GRP [NUM_STEPS] = '{
    GRP_X0, GRP_X0,
    GRP_W1, GRP_W1, GRP_W1,
    GRP_X1, GRP_X1,
    GRP_W2, GRP_W2, GRP_W2,
    GRP_X2, GRP_X2
  };

  localparam logic [NUM_STEPS-1:0] STEP_FIRST = 12'b0100_1010_0101;
  localparam logic [NUM_STEPS-1:0] STEP_LAST  = 12'b1010_0101_0010;

  typedef struct packed {
    logic              load_q;
    logic              load_e;
    logic              mul_en;
    logic              rnd_en;
    logic              update;
    logic [STEP_W-1:0] step;
  } cmd_t;

  function automatic logic signed [DATA_WIDTH-1:0] sat_word(input logic signed [ACC_W-1:0] v);
    logic signed [DATA_WIDTH-1:0] r;
    if (v > ACC_W'(WORD_MAX)) begin
      r = WORD_MAX;
    end else if (v < ACC_W'(WORD_MIN)) begin
      r = WORD_MIN;
    end else begin
      r = v[DATA_WIDTH-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/edsm_if.sv]
// Valid/ready channel interfaces for samples in and levels out.
`default_nettype none

interface edsm_in_if;
  import edsm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface edsm_out_if;
  import edsm_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [LEVEL_W-1:0] level;
  modport source (output valid, output level, input ready);
  modport sink (input valid, input level, output ready);
endinterface

`default_nettype wire

[rtl/edsm_dp.sv]
// Datapath: quantizer, shared multiply-accumulate unit, section results and loop state.
`default_nettype none

module edsm_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  edsm_pkg::cmd_t                        cmd,
  input  logic signed [edsm_pkg::SAMPLE_W-1:0]  sample,
  output logic signed [edsm_pkg::LEVEL_W-1:0]   level
);
  import edsm_pkg::*;

  logic signed [DATA_WIDTH-1:0] fb, d0, d11, d12, d21, d22;
  logic signed [DATA_WIDTH-1:0] q, e;
  logic signed [DATA_WIDTH-1:0] x0, w1, x1, w2, x2;
  logic signed [PROD_W-1:0]     prod;
  logic                         prod_vld;
  logic                         prod_first;
  logic signed [ACC_W-1:0]      acc;

  logic signed [ACC_W-1:0]      x_ext;
  logic signed [DATA_WIDTH-1:0] x_word;
  logic signed [DATA_WIDTH:0]   q_rnd;
  logic signed [5:0]            lvl_raw;
  logic signed [LEVEL_W-1:0]    lvl;
  logic signed [ACC_W-1:0]      e_diff;
  logic signed [DATA_WIDTH-1:0] op;
  logic signed [DATA_WIDTH-1:0] rnd_word;
  logic signed [ACC_W-1:0]      fb_sum;

  always_comb begin
    x_ext   = ((ACC_W'(sample) <<< SH_UP) + ACC_W'(IN_RND)) >>> SH_DN;
    x_word  = sat_word(x_ext);
    q_rnd   = ((DATA_WIDTH+1)'(q) + Q_HALF) >>> FRAC_BITS;
    lvl_raw = q_rnd[5:0];
    if (lvl_raw > LEVEL_MAX) begin
      lvl = LEVEL_MAX[LEVEL_W-1:0];
    end else if (lvl_raw < LEVEL_MIN) begin
      lvl = LEVEL_MIN[LEVEL_W-1:0];
    end else begin
      lvl = lvl_raw[LEVEL_W-1:0];
    end
    e_diff   = ACC_W'(q) - (ACC_W'(lvl) <<< FRAC_BITS);
    rnd_word = sat_word((acc + ACC_HALF) >>> COEF_FRAC);
    fb_sum   = ACC_W'(x0) + ACC_W'(x1) + ACC_W'(x2);
    case (STEP_OP[cmd.step])
      OP_E:    op = e;
      OP_D0:   op = d0;
      OP_D11:  op = d11;
      OP_D12:  op = d12;
      OP_D21:  op = d21;
      OP_D22:  op = d22;
      OP_W1:   op = w1;
      OP_W2:   op = w2;
      default: op = e;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_q) begin
      q <= sat_word(ACC_W'(x_word) + ACC_W'(fb));
    end
    if (cmd.load_e) begin
      e     <= sat_word(e_diff);
      level <= lvl;
    end
    if (cmd.mul_en) begin
      prod       <= PROD_W'(STEP_COEF[cmd.step]) * PROD_W'(op);
      prod_first <= STEP_FIRST[cmd.step];
    end
    if (prod_vld) begin
      acc <= (prod_first ? ACC_W'(0) : acc) + ACC_W'(prod);
    end
    if (cmd.rnd_en) begin
      case (STEP_GRP[cmd.step])
        GRP_X0:  x0 <= rnd_word;
        GRP_W1:  w1 <= rnd_word;
        GRP_X1:  x1 <= rnd_word;
        GRP_W2:  w2 <= rnd_word;
        GRP_X2:  x2 <= rnd_word;
        default: x2 <= rnd_word;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
      fb       <= '0;
      d0       <= '0;
      d11      <= '0;
      d12      <= '0;
      d21      <= '0;
      d22      <= '0;
    end else begin
      prod_vld <= cmd.mul_en;
      if (cmd.update) begin
        fb  <= sat_word(fb_sum);
        d0  <= x0;
        d12 <= d11;
        d11 <= w1;
        d22 <= d21;
        d21 <= w2;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/edsm_ctrl.sv]
// Controller: sequences quantize, multiply-accumulate steps and state update; owns handshakes.
`default_nettype none

module edsm_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output edsm_pkg::cmd_t cmd
);
  import edsm_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ERR    = 6'b000010,
    S_MUL    = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_RND    = 6'b010000,
    S_UPDATE = 6'b100000
  } state_t;

  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    cmd.step   = step;
    in_ready   = (state == S_IDLE) && !rst;
    case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_q = 1'b1;
          state_next = S_ERR;
        end
      end
      S_ERR: begin
        if (!out_valid || out_ready) begin
          cmd.load_e = 1'b1;
          step_next  = '0;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (STEP_LAST[step]) begin
          state_next = S_DRAIN;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      S_DRAIN: begin
        state_next = S_RND;
      end
      S_RND: begin
        cmd.rnd_en = 1'b1;
        if (step == LAST_STEP) begin
          state_next = S_UPDATE;
        end else begin
          step_next  = step + STEP_W'(1);
          state_next = S_MUL;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    if (cmd.load_e) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  a_no_level_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_e |-> (!out_valid || out_ready))
    else $error("level overwritten before it was taken");

  a_round_after_drain: assert property (@(posedge clk) disable iff (rst)
    cmd.rnd_en |-> ($past(state) == S_DRAIN))
    else $error("rounding before accumulator drained");

  a_update_after_last: assert property (@(posedge clk) disable iff (rst)
    cmd.update |-> ($past(cmd.rnd_en) && (step == LAST_STEP)))
    else $error("state update before last section result");

endmodule

`default_nettype wire

[rtl/error_feedback_delta_sigma_modulator.sv]
// Top level of the fifth-order error-feedback delta-sigma modulator.
// Usage:
//   samples: valid/ready channel carrying one signed Q5.27 sample per item.
//   levels:  valid/ready channel carrying one signed 5-bit level (-16..15) per item.
//   Each sample gives exactly one level, in order.
// Sequencing:
//   The sample is registered into the quantizer stage when accepted, and its
//   level once the output register is free. The loop filter update then runs
//   twelve coefficient terms on the one shared multiplier, each section result
//   passing a drain and a round state; a new sample waits for the update.
// Reset:
//   rst clears the feedback value and all section delays to zero and empties
//   the output register; the block is ready for a sample on the next cycle.
// Back-pressure:
//   The output register holds a level until it is taken; a sample may be
//   accepted meanwhile, but its level waits in the quantizer stage until the
//   register is free, which delays the rest of that item by the same amount.
`default_nettype none

module error_feedback_delta_sigma_modulator (
  input  logic      clk,
  input  logic      rst,
  edsm_in_if.sink   samples,
  edsm_out_if.source levels
);
  import edsm_pkg::*;

  cmd_t cmd;

  edsm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (levels.valid),
    .out_ready (levels.ready),
    .cmd       (cmd)
  );

  edsm_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sample (samples.sample),
    .level  (levels.level)
  );

endmodule

`default_nettype wire
